// File: rtl/rpi_pkg.sv
`default_nettype none
package rpi_pkg;

	localparam logic       ACT_FILL  = 1'b0;
	localparam logic       ACT_QUERY = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [19:0] CNT_MAX = 20'hFFFFF;

	typedef struct packed {
		logic               action;
		logic [11:0]        bin_index;
		logic signed [15:0] sample;
	} rpi_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] bin_count;
		logic [15:0] rms;
		logic [15:0] rms_error;
	} rpi_out_t;

	// one bin of the accumulator store
	typedef struct packed {
		logic [35:0] sum;
		logic [49:0] sumsq;
		logic [19:0] cnt;
	} rpi_entry_t;

endpackage
`default_nettype wire

// File: rtl/rpi_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module rpi_div import rpi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [49:0] dividend,
	input  wire logic [20:0] divisor,
	output logic             done,
	output logic [49:0]      quotient
);

	logic [49:0] dvd_q;
	logic [20:0] dvs_q;
	logic [20:0] rem_q;
	logic [5:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [21:0] sh;
	logic        ge;

	assign sh = {rem_q, dvd_q[49]};
	assign ge = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 6'd1;
				if (step_q == 6'd49) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 21'(sh - {1'b0, dvs_q}) : sh[20:0];
			dvd_q <= {dvd_q[48:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

// File: rtl/rpi_sqrt.sv
`default_nettype none
// digit-by-digit integer square root, one root bit per cycle
module rpi_sqrt import rpi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] operand,
	output logic             done,
	output logic [15:0]      root
);

	logic [31:0] op_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [3:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [19:0] sh;
	logic [19:0] trial;
	logic        ge;

	assign sh    = {rem_q, op_q[31:30]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[29:0], 2'b00};
			rem_q  <= ge ? 18'(sh - trial) : sh[17:0];
			root_q <= {root_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// File: rtl/rpi_query.sv
`default_nettype none
// query sequencer: mean, mean square, variance root, error root
module rpi_query import rpi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire rpi_entry_t entry,
	output logic            idle,
	output logic            res_valid,
	output rpi_out_t        res,
	input  wire logic       take
);

	typedef enum logic [8:0] {
		Q_IDLE = 9'b000000001,
		Q_DIVM = 9'b000000010,
		Q_DIVQ = 9'b000000100,
		Q_MUL  = 9'b000001000,
		Q_VAR  = 9'b000010000,
		Q_SQ1  = 9'b000100000,
		Q_MUL2 = 9'b001000000,
		Q_DIVE = 9'b010000000,
		Q_DONE = 9'b100000000
	} q_state_t;

	q_state_t state_q, state_d;

	logic [19:0] cnt_q;
	logic [49:0] sumsq_q;
	logic [16:0] mean_q;
	logic [30:0] msq_q;
	logic [33:0] prod_q;
	logic [15:0] rms_q;
	logic [15:0] err_q;
	logic        err_pend_q;

	logic        div_start;
	logic [49:0] div_dvd;
	logic [20:0] div_dvs;
	logic        div_done;
	logic [49:0] div_quo;
	logic        sq_start;
	logic [31:0] sq_op;
	logic        sq_done;
	logic [15:0] sq_root;

	logic [35:0]        abs_sum;
	logic signed [34:0] diff;
	logic [20:0]        den;

	assign abs_sum = entry.sum[35] ? 36'(-entry.sum) : entry.sum;
	assign diff    = $signed({4'b0000, msq_q}) - $signed({1'b0, prod_q});
	assign den     = {cnt_q - 20'd1, 1'b0};

	rpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	rpi_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_op),
		.done    (sq_done),
		.root    (sq_root)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = {14'd0, abs_sum};
		div_dvs   = {1'b0, entry.cnt};
		sq_start  = 1'b0;
		sq_op     = (diff[34] || diff == '0) ? 32'd0 : diff[31:0];
		unique case (state_q)
			Q_IDLE: begin
				if (start) begin
					if (entry.cnt == '0) begin
						state_d = Q_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = Q_DIVM;
					end
				end
			end
			Q_DIVM: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = sumsq_q;
					div_dvs   = {1'b0, cnt_q};
					state_d   = Q_DIVQ;
				end
			end
			Q_DIVQ: begin
				if (div_done) state_d = Q_MUL;
			end
			Q_MUL: begin
				state_d = Q_VAR;
			end
			Q_VAR: begin
				sq_start = 1'b1;
				state_d  = Q_SQ1;
			end
			Q_SQ1: begin
				if (sq_done) begin
					state_d = (cnt_q < 20'd2) ? Q_DONE : Q_MUL2;
				end
			end
			Q_MUL2: begin
				div_start = 1'b1;
				div_dvd   = {18'd0, 32'(rms_q) * 32'(rms_q)};
				div_dvs   = den;
				state_d   = Q_DIVE;
			end
			Q_DIVE: begin
				if (div_done) begin
					sq_start = 1'b1;
					sq_op    = div_quo[31:0];
				end
				if (sq_done) state_d = Q_DONE;
			end
			Q_DONE: begin
				if (take) state_d = Q_IDLE;
			end
			default: state_d = Q_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= Q_IDLE;
			err_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_start && state_q == Q_MUL2) err_pend_q <= 1'b1;
			if (sq_done && state_q == Q_DIVE) err_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == Q_IDLE && start) begin
			cnt_q   <= entry.cnt;
			sumsq_q <= entry.sumsq;
			rms_q   <= '0;
			err_q   <= '0;
		end
		if (state_q == Q_DIVM && div_done) mean_q <= div_quo[16:0];
		if (state_q == Q_DIVQ && div_done) msq_q <= div_quo[30:0];
		if (state_q == Q_MUL) prod_q <= 34'(mean_q) * 34'(mean_q);
		if (state_q == Q_SQ1 && sq_done) rms_q <= sq_root;
		if (state_q == Q_DIVE && sq_done) err_q <= sq_root;
	end

	assign idle          = state_q == Q_IDLE;
	assign res_valid     = state_q == Q_DONE;
	assign res.status    = ST_OK;
	assign res.bin_count = cnt_q;
	assign res.rms       = rms_q;
	assign res.rms_error = err_q;

`ifndef NO_ASSERTIONS
	a_err_root_in_dive: assert property (@(posedge clk) disable iff (!arst_n)
		err_pend_q |-> state_q == Q_DIVE)
		else $error("error root pending outside its step");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != Q_IDLE) |-> !(div_start && sq_start))
		else $error("divider and root started together");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !take) |=> res_valid)
		else $error("query result dropped before taken");
`endif

endmodule
`default_nettype wire

// File: rtl/per_bin_rms_accumulator.sv
// Fill words: back to back while the output is not stalled, read-modify-write
// of one bin in the store. Query words: three 50-step divides and two 16-step
// roots with two or more samples; two divides and one root with one sample;
// none for an empty bin. For fills and errors the result word is registered
// in stage 1, then in the output register. Reset (arst_n low) clears control;
// then a clearing pass zeroes every bin of the store, with in_stall held high.
`default_nettype none
module per_bin_rms_accumulator import rpi_pkg::*; #(
	parameter int NUM_BINS = 256
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire rpi_in_t in_word,
	output logic         out_valid,
	input  wire logic    out_stall,
	output rpi_out_t     out_word
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	// bin store: sum, sum of squares and count packed in one word
	rpi_entry_t mem [NUM_BINS];
	rpi_entry_t rdata_q;

	// clearing pass after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// stage 1: item with its read data
	logic          valid_s1;
	rpi_in_t       item_s1;
	logic [30:0]   sq_s1;
	logic          inrange_s1;

	// last write, forwarded to a read issued in the same cycle
	logic          fwd_vld_q;
	logic [AW-1:0] fwd_addr_q;
	rpi_entry_t    fwd_q;

	logic          out_valid_q;
	rpi_out_t      out_word_q;

	logic               acc;
	logic [AW-1:0]      addr_s1;
	rpi_entry_t         cur;
	rpi_entry_t         upd;
	logic               is_query;
	logic               out_free;
	logic               fill_go;
	logic               qry_go;
	logic               fill_we;
	logic               we;
	logic [AW-1:0]      waddr;
	rpi_entry_t         wdata;
	logic signed [31:0] sq_prod;
	rpi_out_t           fill_res;

	logic     eng_idle;
	logic     eng_valid;
	rpi_out_t eng_res;
	logic     eng_take;

	assign addr_s1  = item_s1.bin_index[AW-1:0];
	assign cur      = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_q : rdata_q;
	assign is_query = item_s1.action == ACT_QUERY;
	assign out_free = !out_valid_q || !out_stall;

	// fills and errors retire from stage 1; queries go to the sequencer
	assign fill_go  = valid_s1 && (!inrange_s1 || !is_query) && out_free;
	assign qry_go   = valid_s1 && inrange_s1 && is_query && eng_idle;
	assign fill_we  = fill_go && inrange_s1 && !is_query && cur.cnt != CNT_MAX;
	assign eng_take = eng_valid && out_free;

	assign in_stall = clr_q || !eng_idle || (valid_s1 && !fill_go);
	assign acc      = in_valid && !in_stall;

	assign sq_prod = $signed({{16{in_word.sample[15]}}, in_word.sample})
		* $signed({{16{in_word.sample[15]}}, in_word.sample});

	assign upd.sum   = cur.sum + {{20{item_s1.sample[15]}}, item_s1.sample};
	assign upd.sumsq = cur.sumsq + {19'd0, sq_s1};
	assign upd.cnt   = cur.cnt + 20'd1;

	assign we    = clr_q || fill_we;
	assign waddr = clr_q ? clr_addr_q : addr_s1;
	assign wdata = clr_q ? '0 : upd;

	always_comb begin
		fill_res = '0;
		if (!inrange_s1) begin
			fill_res.status = ST_RANGE;
		end else if (!is_query && cur.cnt == CNT_MAX) begin
			fill_res.status = ST_FULL;
		end else begin
			fill_res.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (acc) rdata_q <= mem[in_word.bin_index[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			valid_s1    <= 1'b0;
			fwd_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(NUM_BINS - 1)) clr_q <= 1'b0;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (fill_go || qry_go) begin
				valid_s1 <= 1'b0;
			end
			if (fill_we) fwd_vld_q <= 1'b1;
			if (eng_take || fill_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1    <= in_word;
			sq_s1      <= sq_prod[30:0];
			inrange_s1 <= {1'b0, in_word.bin_index} < 13'(NUM_BINS);
		end
		if (fill_we) begin
			fwd_addr_q <= addr_s1;
			fwd_q      <= upd;
		end
		if (eng_take) begin
			out_word_q <= eng_res;
		end else if (fill_go) begin
			out_word_q <= fill_res;
		end
	end

	rpi_query u_query (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (qry_go),
		.entry     (cur),
		.idle      (eng_idle),
		.res_valid (eng_valid),
		.res       (eng_res),
		.take      (eng_take)
	);

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

`ifndef NO_ASSERTIONS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall)
		else $error("word accepted during clearing pass");
	a_query_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!eng_idle |-> !valid_s1)
		else $error("stage 1 occupied while query runs");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		fill_we |-> !clr_q)
		else $error("fill write during clearing pass");
	a_no_double_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(eng_take && fill_go))
		else $error("two results loaded at once");
`endif

endmodule
`default_nettype wire
